>>> rtl/ssbst_pkg.sv
// Shared constants, types and codes for the sorted set binary search table.
package ssbst_pkg;

    localparam int CAPACITY  = 256;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 16;
    localparam int IDX_W     = 8;
    localparam int POS_W     = 8;
    localparam int OCNT_W    = 9;
    localparam int STAT_W    = 3;
    localparam int KIND_W    = 2;
    localparam int CMP_W     = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - POS_W - VAL_W - OCNT_W;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CNT_W:0]           cnt_sum_t;
    typedef logic [VAL_W-1:0]         val_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [OCNT_W-1:0]        ocnt_t;
    typedef logic [STAT_W-1:0]        stat_t;
    typedef logic [KIND_W-1:0]        kind_t;
    typedef logic [CMP_W-1:0]         cmp_t;

    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_FIND   = 2'd1;
    localparam kind_t KIND_GET    = 2'd2;

    localparam stat_t STAT_OK      = 3'd0;
    localparam stat_t STAT_PRESENT = 3'd1;
    localparam stat_t STAT_ABSENT  = 3'd2;
    localparam stat_t STAT_FULL    = 3'd3;
    localparam stat_t STAT_RANGE   = 3'd4;

endpackage

>>> rtl/sorted_set_binary_search_table_top.sv
// Sorted set table: binary search, insert with shift, find and get over one RAM.
//
// The table keeps up to 256 distinct signed 16-bit values in ascending order in one
// synchronous RAM and works on one request at a time; s_tready is high only while the block
// is idle. A request of an unused kind or a get whose index is not below the count goes
// straight to the done state, where the result is loaded into the output register; a valid
// get first reads its entry. Find and insert first run a binary search that reads one RAM
// entry per cycle, with at most floor(log2(count))+1 reads; a find, a duplicate insert or an
// insert into a full table then passes through the result state to the done state. An
// insert of a new value at slot p moves every entry from p upwards by one slot, one entry per
// cycle through the RAM's single write port, and then writes the new value at slot p. The
// next request can be accepted in the cycle after the result is loaded. The result waits
// in an output register; a request that finishes while the previous result has not yet
// been taken holds there until m_tready frees the register.
module sorted_set_binary_search_table_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ssbst_pkg::S_TDATA_W-1:0] s_tdata,  // value[15:0], index[23:16]
    input  logic [ssbst_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssbst_pkg::M_TDATA_W-1:0] m_tdata,  // position[7:0], entry[23:8],
                                                      // count[32:24], zero[39:33]
    output logic [ssbst_pkg::STAT_W-1:0]    m_tuser   // status[2:0]
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;
    localparam logic [2:0] ST_RES   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_INS   = 3'd4;
    localparam logic [2:0] ST_GET   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]       state_reg, state_next;
    ssbst_pkg::kind_t kind_reg, kind_next;
    ssbst_pkg::val_t  value_reg, value_next;
    ssbst_pkg::cnt_t  lo_reg, lo_next;
    ssbst_pkg::cnt_t  hi_reg, hi_next;
    ssbst_pkg::addr_t mid_reg, mid_next;
    logic             found_reg, found_next;
    ssbst_pkg::cnt_t  slot_reg, slot_next;
    ssbst_pkg::cnt_t  sp_reg, sp_next;
    logic             wpend_reg, wpend_next;
    ssbst_pkg::addr_t wa_reg, wa_next;
    ssbst_pkg::cnt_t  count_reg, count_next;

    ssbst_pkg::stat_t res_status_reg, res_status_next;
    ssbst_pkg::pos_t  res_pos_reg, res_pos_next;
    ssbst_pkg::val_t  res_entry_reg, res_entry_next;
    ssbst_pkg::ocnt_t res_count_reg, res_count_next;

    logic             out_valid_reg, out_valid_next;
    ssbst_pkg::stat_t out_status_reg, out_status_next;
    ssbst_pkg::pos_t  out_pos_reg, out_pos_next;
    ssbst_pkg::val_t  out_entry_reg, out_entry_next;
    ssbst_pkg::ocnt_t out_count_reg, out_count_next;

    logic             ram_we;
    ssbst_pkg::addr_t ram_waddr;
    ssbst_pkg::val_t  ram_wdata;
    logic             ram_re;
    ssbst_pkg::addr_t ram_raddr;
    ssbst_pkg::val_t  ram_rdata;

    ssbst_ram #(
        .WIDTH (ssbst_pkg::VAL_W),
        .DEPTH (ssbst_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{ssbst_pkg::M_PAD_W{1'b0}}, out_count_reg, out_entry_reg, out_pos_reg};

    always_comb
    begin
        ssbst_pkg::idx_t     idx_in;
        ssbst_pkg::cnt_t     lo_n;
        ssbst_pkg::cnt_t     hi_n;
        ssbst_pkg::cnt_sum_t sum;
        ssbst_pkg::cnt_t     count_inc;

        state_next      = state_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        sp_next         = sp_reg;
        wpend_next      = wpend_reg;
        wa_next         = wa_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_entry_next  = res_entry_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        idx_in    = s_tdata[ssbst_pkg::VAL_W +: ssbst_pkg::IDX_W];
        lo_n      = lo_reg;
        hi_n      = hi_reg;
        sum       = '0;
        count_inc = count_reg + ssbst_pkg::cnt_t'(1);

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next      = s_tuser;
                    value_next     = s_tdata[ssbst_pkg::VAL_W-1:0];
                    res_status_next = ssbst_pkg::STAT_OK;
                    res_pos_next   = '0;
                    res_entry_next = '0;
                    res_count_next = ssbst_pkg::ocnt_t'(count_reg);
                    case (s_tuser)
                        ssbst_pkg::KIND_INSERT, ssbst_pkg::KIND_FIND:
                        begin
                            lo_next = '0;
                            hi_next = count_reg;
                            if (count_reg == '0)
                            begin
                                found_next = 1'b0;
                                slot_next  = '0;
                                state_next = ST_RES;
                            end
                            else
                            begin
                                mid_next   = ssbst_pkg::addr_t'(count_reg >> 1);
                                ram_re     = 1'b1;
                                ram_raddr  = ssbst_pkg::addr_t'(count_reg >> 1);
                                state_next = ST_SRCH;
                            end
                        end
                        ssbst_pkg::KIND_GET:
                        begin
                            if (ssbst_pkg::cmp_t'(idx_in) < ssbst_pkg::cmp_t'(count_reg))
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = ssbst_pkg::addr_t'(idx_in);
                                res_pos_next = ssbst_pkg::pos_t'(idx_in);
                                state_next   = ST_GET;
                            end
                            else
                            begin
                                res_status_next = ssbst_pkg::STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SRCH:
            begin
                if ($signed(ram_rdata) == $signed(value_reg))
                begin
                    found_next = 1'b1;
                    slot_next  = ssbst_pkg::cnt_t'(mid_reg);
                    state_next = ST_RES;
                end
                else
                begin
                    if ($signed(ram_rdata) > $signed(value_reg))
                    begin
                        hi_n = ssbst_pkg::cnt_t'(mid_reg);
                    end
                    else
                    begin
                        lo_n = ssbst_pkg::cnt_t'(mid_reg) + ssbst_pkg::cnt_t'(1);
                    end
                    lo_next = lo_n;
                    hi_next = hi_n;
                    if (lo_n < hi_n)
                    begin
                        sum       = ssbst_pkg::cnt_sum_t'(lo_n) + ssbst_pkg::cnt_sum_t'(hi_n);
                        mid_next  = ssbst_pkg::addr_t'(sum >> 1);
                        ram_re    = 1'b1;
                        ram_raddr = ssbst_pkg::addr_t'(sum >> 1);
                    end
                    else
                    begin
                        found_next = 1'b0;
                        slot_next  = lo_n;
                        state_next = ST_RES;
                    end
                end
            end

            ST_RES:
            begin
                state_next = ST_DONE;
                if (kind_reg == ssbst_pkg::KIND_FIND)
                begin
                    if (found_reg)
                    begin
                        res_pos_next = ssbst_pkg::pos_t'(slot_reg);
                    end
                    else
                    begin
                        res_status_next = ssbst_pkg::STAT_ABSENT;
                    end
                end
                else if (found_reg)
                begin
                    res_status_next = ssbst_pkg::STAT_PRESENT;
                    res_pos_next    = ssbst_pkg::pos_t'(slot_reg);
                end
                else if (count_reg == ssbst_pkg::cnt_t'(ssbst_pkg::CAPACITY))
                begin
                    res_status_next = ssbst_pkg::STAT_FULL;
                end
                else
                begin
                    sp_next    = count_reg;
                    wpend_next = 1'b0;
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // The entry read last cycle lands one slot higher while the next one is read.
                if (wpend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                wpend_next = 1'b0;
                if (sp_reg > slot_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ssbst_pkg::addr_t'(sp_reg - ssbst_pkg::cnt_t'(1));
                    wa_next    = ssbst_pkg::addr_t'(sp_reg);
                    wpend_next = 1'b1;
                    sp_next    = sp_reg - ssbst_pkg::cnt_t'(1);
                end
                else
                begin
                    state_next = ST_INS;
                end
            end

            ST_INS:
            begin
                ram_we         = 1'b1;
                ram_waddr      = ssbst_pkg::addr_t'(slot_reg);
                ram_wdata      = value_reg;
                count_next     = count_inc;
                res_pos_next   = ssbst_pkg::pos_t'(slot_reg);
                res_count_next = ssbst_pkg::ocnt_t'(count_inc);
                state_next     = ST_DONE;
            end

            ST_GET:
            begin
                res_entry_next = ram_rdata;
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_entry_next  = res_entry_reg;
                    out_count_next  = res_count_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wpend_reg     <= wpend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        sp_reg         <= sp_next;
        wa_reg         <= wa_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_entry_reg  <= res_entry_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
    end

endmodule

>>> rtl/ssbst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ssbst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> test/tb.sv
// Self-checking testbench for the sorted set binary search table.
`timescale 1ns / 1ps

module tb;
    import ssbst_pkg::*;

    localparam kind_t KIND_UNUSED = 2'd3;
    localparam int    IDLE_LIMIT  = 2000;
    localparam int    DRAIN_WAIT  = 300;
    localparam int    RANDOM_REQS = 1300;
    localparam int    REPORT_MAX  = 10;

    typedef struct packed {
        stat_t              status;
        pos_t               position;
        val_t               entry;
        ocnt_t              count;
        logic [M_PAD_W-1:0] pad;
    } answer_t;

    class sorted_set_mirror;
        val_t          store[CAPACITY];
        int unsigned   held;
        answer_t       pending_answers[$];
        int            failures;
        int            kind_seen[4];
        int            status_seen[8];

        function new();
            held     = 0;
            failures = 0;
            foreach (store[i]) store[i] = '0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Binary search; slot receives the match or the insertion point.
        function bit locate_slot(val_t v, output int unsigned slot);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = held;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if ($signed(store[mid]) > $signed(v))
                    hi = mid;
                else if ($signed(store[mid]) < $signed(v))
                    lo = mid + 1;
                else
                begin
                    slot = mid;
                    return 1'b1;
                end
            end
            slot = lo;
            return 1'b0;
        endfunction

        function void note_request(kind_t kind, val_t value, idx_t index);
            answer_t     ans;
            int unsigned slot;
            int          k;
            ans = '0;
            kind_seen[kind]++;
            case (kind)
                KIND_INSERT:
                begin
                    if (locate_slot(value, slot))
                    begin
                        ans.status   = STAT_PRESENT;
                        ans.position = pos_t'(slot);
                    end
                    else if (held >= CAPACITY)
                        ans.status = STAT_FULL;
                    else
                    begin
                        for (k = held; k > slot; k--)
                            store[k] = store[k-1];
                        store[slot]  = value;
                        held++;
                        ans.status   = STAT_OK;
                        ans.position = pos_t'(slot);
                    end
                end
                KIND_FIND:
                begin
                    if (locate_slot(value, slot))
                        ans.position = pos_t'(slot);
                    else
                        ans.status = STAT_ABSENT;
                end
                KIND_GET:
                begin
                    if (index < held)
                    begin
                        ans.position = index;
                        ans.entry    = store[index];
                    end
                    else
                        ans.status = STAT_RANGE;
                end
                default:
                    ans.status = STAT_OK;
            endcase
            ans.count = ocnt_t'(held);
            pending_answers.push_back(ans);
        endfunction

        function void check_response(stat_t st, logic [M_TDATA_W-1:0] word);
            answer_t got;
            answer_t want;
            got.status   = st;
            got.position = word[POS_W-1:0];
            got.entry    = word[POS_W +: VAL_W];
            got.count    = word[POS_W+VAL_W +: OCNT_W];
            got.pad      = word[M_TDATA_W-1 -: M_PAD_W];
            status_seen[st]++;
            if (pending_answers.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: response with none outstanding: status %0d word %h",
                             $realtime, st, word);
                return;
            end
            want = pending_answers.pop_front();
            if (got.status != want.status || got.position != want.position ||
                got.entry != want.entry || got.count != want.count || got.pad != want.pad)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display({"%0t: mismatch: expected status %0d pos %0d entry %0d count %0d",
                              " pad %h, got status %0d pos %0d entry %0d count %0d pad %h"},
                             $realtime, want.status, want.position, $signed(want.entry),
                             want.count, want.pad, got.status, got.position,
                             $signed(got.entry), got.count, got.pad);
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    sorted_set_mirror mirror;
    bit               steady = 1'b0;
    int               ready_left = 0;
    int               idle_cycles = 0;

    sorted_set_binary_search_table_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver back-pressure: mostly ready, short stalls, now and then a long one.
    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_left <= 0;
        end
        else if (ready_left == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(100, 300);
            end
            else if (r < 65)
            begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(0, 20);
            end
            else if (r < 90)
            begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(0, 3);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(10, 40);
            end
        end
        else
            ready_left <= ready_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_response(m_tuser, m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one request and holds it until the transaction completes.
    task automatic send_request(kind_t kind, val_t value, idx_t index);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {index, value};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        mirror.note_request(kind, value, index);
    endtask

    // Extremes, a narrow cluster to provoke duplicates and neighbours, or anything.
    function automatic val_t random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        else if (r < 30)
            return val_t'($urandom_range(0, 128) - 64);
        return val_t'($urandom);
    endfunction

    function automatic val_t stored_value();
        return mirror.store[$urandom_range(0, mirror.held - 1)];
    endfunction

    initial
    begin
        int   r;
        val_t v;
        idx_t ix;
        mirror = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty table, extremes, duplicates, range edges.
        send_request(KIND_GET,    16'h0000, 8'd0);
        send_request(KIND_FIND,   16'h0000, 8'd0);
        send_request(KIND_UNUSED, 16'h0000, 8'd0);
        send_request(KIND_INSERT, 16'h0000, 8'd0);
        send_request(KIND_INSERT, 16'h8000, 8'hFF);
        send_request(KIND_INSERT, 16'h7FFF, 8'd0);
        send_request(KIND_INSERT, 16'hFFFF, 8'd0);
        send_request(KIND_INSERT, 16'h0001, 8'd0);
        send_request(KIND_INSERT, 16'h0000, 8'd0);
        send_request(KIND_INSERT, 16'h7FFF, 8'd0);
        send_request(KIND_FIND,   16'h8000, 8'd0);
        send_request(KIND_FIND,   16'h7FFF, 8'd0);
        send_request(KIND_FIND,   16'h0002, 8'd0);
        send_request(KIND_FIND,   16'h8001, 8'd0);
        send_request(KIND_GET,    16'hFFFF, 8'd0);
        send_request(KIND_GET,    16'h0000, 8'd4);
        send_request(KIND_GET,    16'h0000, 8'd5);
        send_request(KIND_GET,    16'h0000, 8'hFF);
        send_request(KIND_UNUSED, 16'hFFFF, 8'hFF);
        send_request(KIND_INSERT, 16'hFFFE, 8'd0);
        send_request(KIND_INSERT, 16'h0064, 8'd0);

        // Random mix; insert-heavy enough that the table fills well before the end.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 50 == 0)
                steady = ($urandom_range(0, 99) < 30);
            r  = $urandom_range(0, 99);
            ix = idx_t'($urandom_range(0, 255));
            if (r < 45)
            begin
                if (mirror.held > 0 && $urandom_range(0, 4) == 0)
                    v = stored_value();
                else
                    v = random_value();
                send_request(KIND_INSERT, v, ix);
            end
            else if (r < 70)
            begin
                if (mirror.held > 0 && $urandom_range(0, 1) == 0)
                    v = stored_value() + val_t'($urandom_range(0, 2) - 1);
                else
                    v = random_value();
                send_request(KIND_FIND, v, ix);
            end
            else if (r < 95)
            begin
                if (mirror.held > 0 && $urandom_range(0, 9) < 7)
                    ix = idx_t'($urandom_range(0, mirror.held - 1));
                send_request(KIND_GET, val_t'($urandom), ix);
            end
            else
                send_request(KIND_UNUSED, val_t'($urandom), ix);
        end
        s_tvalid <= 1'b0;

        while (mirror.pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        mirror.failures += mirror.pending_answers.size();

        $display("Covered %0d inserts, %0d finds, %0d gets and %0d unused-kind requests; %0d %s",
                 mirror.kind_seen[KIND_INSERT], mirror.kind_seen[KIND_FIND],
                 mirror.kind_seen[KIND_GET], mirror.kind_seen[KIND_UNUSED], mirror.held,
                 "entries held at the end.");
        $display("Responses: %0d ok, %0d duplicate, %0d absent, %0d full, %0d out of range; %0d %s",
                 mirror.status_seen[STAT_OK], mirror.status_seen[STAT_PRESENT],
                 mirror.status_seen[STAT_ABSENT], mirror.status_seen[STAT_FULL],
                 mirror.status_seen[STAT_RANGE], mirror.failures, "failures.");
        if (mirror.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
